// ===== rtl/core/smf_pkg.sv =====
package smf_pkg;

    localparam int WIN_LEN  = 5;
    localparam int SAMPLE_W = 16;
    // Counter wide enough to hold WIN_LEN itself.
    localparam int CNT_W    = $clog2(WIN_LEN + 1);
    localparam int SLOT_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    // Largest values pulled out, up to and including the median (lower middle when even).
    localparam int EXT_N    = WIN_LEN / 2 + 1;
    localparam int EXT_W    = $clog2(EXT_N + 1);
    localparam bit EVEN_LEN = ((WIN_LEN % 2) == 0);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t win_t [WIN_LEN];

    typedef struct packed {
        logic ready;
        logic res_valid;
    } eng_status_t;

endpackage

// ===== rtl/core/smf_window.sv =====
module smf_window (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  smf_pkg::sample_t wr_data,
    output smf_pkg::win_t    win
);

    smf_pkg::sample_t                    win_reg [smf_pkg::WIN_LEN];
    logic [smf_pkg::SLOT_W-1:0]          slot_reg;
    logic [smf_pkg::SLOT_W-1:0]          slot_next;

    always_comb
    begin
        if (slot_reg == smf_pkg::SLOT_W'(smf_pkg::WIN_LEN - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + smf_pkg::SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            for (int i = 0; i < smf_pkg::WIN_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            win_reg[slot_reg] <= wr_data;
            slot_reg          <= slot_next;
        end
    end

    assign win = win_reg;

endmodule

// ===== rtl/core/smf_engine.sv =====
module smf_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  smf_pkg::win_t        win,
    input  logic                 res_take,
    output smf_pkg::eng_status_t status,
    output smf_pkg::sample_t     res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_PICK,
        S_STEP,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    smf_pkg::sample_t             q_reg [smf_pkg::WIN_LEN];
    smf_pkg::sample_t             q_next [smf_pkg::WIN_LEN];
    smf_pkg::sample_t             carry_reg, carry_next;
    smf_pkg::sample_t             prev_reg, prev_next;
    smf_pkg::sample_t             res_reg, res_next;
    logic [smf_pkg::CNT_W-1:0]    u_reg, u_next;
    logic [smf_pkg::CNT_W-1:0]    step_reg, step_next;
    logic [smf_pkg::EXT_W-1:0]    ext_reg, ext_next;

    // Shared compare unit: running maximum against queue head.
    smf_pkg::sample_t             hi;
    smf_pkg::sample_t             lo;
    logic                         pass_end;
    smf_pkg::sample_t             pass_max;
    logic signed [smf_pkg::SAMPLE_W:0] pair_sum;
    smf_pkg::sample_t             median_val;

    always_comb
    begin
        if (carry_reg >= q_reg[0])
        begin
            hi = carry_reg;
            lo = q_reg[0];
        end
        else
        begin
            hi = q_reg[0];
            lo = carry_reg;
        end
    end

    // Even length: floor mean of the middle pair via 17-bit sum.
    always_comb
    begin
        pair_sum = {prev_reg[smf_pkg::SAMPLE_W-1], prev_reg}
                 + {pass_max[smf_pkg::SAMPLE_W-1], pass_max};
        if (smf_pkg::EVEN_LEN)
        begin
            median_val = pair_sum[smf_pkg::SAMPLE_W:1];
        end
        else
        begin
            median_val = pass_max;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_next     = q_reg;
        carry_next = carry_reg;
        prev_next  = prev_reg;
        res_next   = res_reg;
        u_next     = u_reg;
        step_next  = step_reg;
        ext_next   = ext_reg;
        pass_end   = 1'b0;
        pass_max   = q_reg[0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                q_next     = win;
                u_next     = smf_pkg::CNT_W'(smf_pkg::WIN_LEN);
                ext_next   = '0;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                carry_next = q_reg[0];
                for (int i = 0; i < smf_pkg::WIN_LEN - 1; i++)
                begin
                    q_next[i] = q_reg[i + 1];
                end
                u_next    = u_reg - smf_pkg::CNT_W'(1);
                step_next = u_reg - smf_pkg::CNT_W'(1);
                if (u_reg == smf_pkg::CNT_W'(1))
                begin
                    pass_end = 1'b1;
                    pass_max = q_reg[0];
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                carry_next = hi;
                // Rotate the live part of the queue, loser goes to its tail.
                for (int i = 0; i < smf_pkg::WIN_LEN - 1; i++)
                begin
                    if (smf_pkg::CNT_W'(i + 1) == u_reg)
                    begin
                        q_next[i] = lo;
                    end
                    else
                    begin
                        q_next[i] = q_reg[i + 1];
                    end
                end
                q_next[smf_pkg::WIN_LEN-1] = lo;
                step_next = step_reg - smf_pkg::CNT_W'(1);
                if (step_reg == smf_pkg::CNT_W'(1))
                begin
                    pass_end = 1'b1;
                    pass_max = hi;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pass_end)
        begin
            prev_next = pass_max;
            ext_next  = ext_reg + smf_pkg::EXT_W'(1);
            if (ext_reg == smf_pkg::EXT_W'(smf_pkg::EXT_N - 1))
            begin
                res_next   = median_val;
                state_next = S_DONE;
            end
            else
            begin
                state_next = S_PICK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            u_reg     <= '0;
            step_reg  <= '0;
            ext_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            u_reg     <= u_next;
            step_reg  <= step_next;
            ext_reg   <= ext_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        carry_reg <= carry_next;
        prev_reg  <= prev_next;
        res_reg   <= res_next;
    end

    assign status.ready     = (state_reg == S_IDLE);
    assign status.res_valid = (state_reg == S_DONE);
    assign res              = res_reg;

endmodule

// ===== rtl/core/sliding_median_filter_core.sv =====
// Sliding-window median filter.
//
// Input channel (sample_valid / sample_stall / sample): one signed 16-bit
// sample per item. It overwrites the oldest entry of a circular window of
// WIN_LEN samples; the window is all zero after reset, so early results
// include those zeros.
// Output channel (median_valid / median_stall / median): one item per
// sample, the median of the window (floor mean of the middle pair when the
// length is even).
// Search: the median is found by pulling the running maximum out of the
// window WIN_LEN/2+1 times through a single comparator, each pass over
// the entries not yet pulled out. The sequence runs through the copy,
// pick and step states to the hand-off state; a new sample is taken only
// after the result has been handed to the output register, so the core
// works on one sample at a time.
// Reset (rst_n, asynchronous, active low) clears the window, write slot,
// sequencer and output valid.
// A stalled result stays in the output register; the engine holds its
// finished result until the register frees, and meanwhile stalls input.
module sliding_median_filter_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  smf_pkg::sample_t sample,
    output logic             median_valid,
    input  logic             median_stall,
    output smf_pkg::sample_t median
);

    smf_pkg::win_t        win;
    smf_pkg::eng_status_t eng_status;
    smf_pkg::sample_t     eng_res;
    logic                 in_take;
    logic                 res_take;
    logic                 out_valid_reg;
    smf_pkg::sample_t     median_reg;

    // Busy from acceptance until the result is handed to the output register.
    assign sample_stall = !eng_status.ready;
    assign in_take      = sample_valid && !sample_stall;

    // Output register frees when empty or drained this cycle.
    assign res_take = eng_status.res_valid && (!out_valid_reg || !median_stall);

    smf_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_take),
        .wr_data (sample),
        .win     (win)
    );

    // Engine starts on acceptance and copies the updated window in the next cycle.
    smf_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_take),
        .win      (win),
        .res_take (res_take),
        .status   (eng_status),
        .res      (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!median_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            median_reg <= eng_res;
        end
    end

    assign median_valid = out_valid_reg;
    assign median       = median_reg;

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_take |=> sample_stall
    ) else $error("input taken while engine busy");

    a_status_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(eng_status.ready && eng_status.res_valid)
    ) else $error("engine idle and done at once");

    a_handoff_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_take |=> median_valid
    ) else $error("result lost on hand-off");

    a_output_from_engine: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(median_valid) |-> $past(eng_status.res_valid)
    ) else $error("output valid without a finished result");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the sliding-window median filter core.
// A queue of samples is filled up front: directed patterns first, then
// constrained-looking random traffic built with $urandom. A clocked driver
// feeds the queue into the sample channel with random gaps. A clocked
// monitor drains the median channel with random stalls. Every accepted
// sample runs through a behavioural window model, and the median it
// predicts is queued. That prediction is then compared with the next
// median the core emits.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1350;
    // Neither side idles for a stretch in the middle of the run.
    localparam int CALM_FROM    = 500;
    localparam int CALM_TO      = 700;
    localparam int IDLE_PCT     = 19;
    // Cycles allowed after the final median before the run is closed.
    localparam int DRAIN_CYCLES = 40;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             sample_valid = 1'b0;
    logic             sample_stall;
    smf_pkg::sample_t sample = '0;
    logic             median_valid;
    logic             median_stall = 1'b0;
    smf_pkg::sample_t median;

    sliding_median_filter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .median_valid (median_valid),
        .median_stall (median_stall),
        .median       (median)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioural window: circular store plus write pointer. It mirrors
    // the core's state after each accepted item.
    // ------------------------------------------------------------------
    smf_pkg::sample_t window_buf [smf_pkg::WIN_LEN];
    int               next_slot;

    smf_pkg::sample_t pending_samples [$];
    smf_pkg::sample_t expected_medians [$];

    int               n_sent;
    int               n_checked;
    int               n_errors;
    bit               hold_off;
    smf_pkg::sample_t want;

    // Writes one sample into the window and returns the median of the
    // window that results. An even length takes the floor of the mean of
    // the middle pair: the sum is formed wide and shifted arithmetically.
    function automatic smf_pkg::sample_t median_after_write(smf_pkg::sample_t s);
        smf_pkg::sample_t srt [smf_pkg::WIN_LEN];
        smf_pkg::sample_t key;
        int               j;
        int               pair_sum;
        window_buf[next_slot] = s;
        next_slot = (next_slot >= smf_pkg::WIN_LEN - 1) ? 0 : next_slot + 1;
        foreach (window_buf[i])
            srt[i] = window_buf[i];
        for (int i = 1; i < smf_pkg::WIN_LEN; i++)
        begin
            key = srt[i];
            j = i - 1;
            while (j >= 0)
            begin
                if (srt[j] <= key)
                    break;
                srt[j + 1] = srt[j];
                j--;
            end
            srt[j + 1] = key;
        end
        if (!smf_pkg::EVEN_LEN)
            return srt[smf_pkg::WIN_LEN / 2];
        pair_sum = int'(srt[smf_pkg::WIN_LEN / 2 - 1]) + int'(srt[smf_pkg::WIN_LEN / 2]);
        return smf_pkg::sample_t'(pair_sum >>> 1);
    endfunction

    // ------------------------------------------------------------------
    // Driver. A held item stays on the bus, untouched, while stalled. Once
    // it has been taken (or the bus was idle), the next item goes out,
    // unless a random gap is drawn.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                expected_medians.push_back(median_after_write(sample));
                n_sent = n_sent + 1;
            end
            if (!sample_valid || !sample_stall)
            begin
                hold_off = !(n_sent >= CALM_FROM && n_sent < CALM_TO) &&
                           ($urandom_range(99) < IDLE_PCT);
                if (pending_samples.size() != 0 && !hold_off)
                begin
                    sample       <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. It checks each median taken at this edge, then draws the
    // stall for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            median_stall <= 1'b0;
        else
        begin
            if (median_valid && !median_stall)
            begin
                if (expected_medians.size() == 0)
                begin
                    $display("%0t: median %0d with nothing expected", $time, median);
                    n_errors = n_errors + 1;
                end
                else
                begin
                    want = expected_medians.pop_front();
                    if (median !== want)
                    begin
                        $display("%0t: median mismatch, expected %0d got %0d",
                                 $time, want, median);
                        n_errors = n_errors + 1;
                    end
                    n_checked = n_checked + 1;
                end
            end
            median_stall <= !(n_checked >= CALM_FROM && n_checked < CALM_TO) &&
                            ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and the end of the run.
    // ------------------------------------------------------------------
    initial
    begin
        int               target;
        int               pick;
        int               run_len;
        smf_pkg::sample_t prev;
        smf_pkg::sample_t run_val;

        foreach (window_buf[i])
            window_buf[i] = '0;
        next_slot = 0;
        n_sent    = 0;
        n_checked = 0;
        n_errors  = 0;

        // Directed part. The window starts out full of zeros, so the first
        // few medians come from a window that is not yet full. After that
        // the window is filled with the extremes, then with ties. Near-zero
        // odd pairs check the rounding when the length is even.
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(-16'sh8000);
        pending_samples.push_back(16'sh7FFF);
        for (int i = 0; i < smf_pkg::WIN_LEN + 1; i++)
            pending_samples.push_back(-16'sh8000);
        for (int i = 0; i < smf_pkg::WIN_LEN + 1; i++)
            pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sd7);
        pending_samples.push_back(16'sd7);
        pending_samples.push_back(16'sd7);
        pending_samples.push_back(-16'sd3);
        pending_samples.push_back(16'sd0);
        pending_samples.push_back(-16'sd3);
        pending_samples.push_back(-16'sd1);
        pending_samples.push_back(16'sd1);
        pending_samples.push_back(16'sh5555);
        pending_samples.push_back(16'shAAAA);

        // Random part. Full-range values so that every bit toggles, small
        // values close to zero that give many ties, extremes, runs of one
        // value, and values close to the previous one so that the window
        // is nearly sorted.
        target = pending_samples.size() + RANDOM_ITEMS;
        prev   = '0;
        while (pending_samples.size() < target)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                prev = smf_pkg::sample_t'($urandom);
            else if (pick < 55)
                prev = smf_pkg::sample_t'(int'($urandom_range(16)) - 8);
            else if (pick < 65)
            begin
                case ($urandom_range(4))
                    0: prev = 16'sh7FFF;
                    1: prev = -16'sh8000;
                    2: prev = -16'sd1;
                    3: prev = 16'sd1;
                    default: prev = 16'sd0;
                endcase
            end
            else if (pick < 80)
            begin
                run_val = smf_pkg::sample_t'($urandom);
                run_len = $urandom_range(smf_pkg::WIN_LEN + 2, 2);
                for (int i = 1; i < run_len; i++)
                    pending_samples.push_back(run_val);
                prev = run_val;
            end
            else
                prev = smf_pkg::sample_t'(int'(prev) + int'($urandom_range(64)) - 32);
            pending_samples.push_back(prev);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item has been taken and every median checked,
        // then give the core time to put out any stray result.
        while (pending_samples.size() != 0 || sample_valid ||
               expected_medians.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d medians from %0d samples: extremes, ties, partly filled window,",
                 n_checked, n_sent);
        $display("runs, near-sorted and full-range random data, with random gaps and stalls.");
        if (n_errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #2_000_000;
        $display("Timed out after %0d of %0d medians", n_checked, n_sent);
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sliding_median_filter_core.f =====
rtl/core/smf_pkg.sv
rtl/core/smf_window.sv
rtl/core/smf_engine.sv
rtl/core/sliding_median_filter_core.sv
tb/sv/tb_top.sv
